### hw/rtl/pva_pkg.sv
// types and constants shared by the voice allocator modules
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam logic [1:0] CMD_MIDI     = 2'd0;
    localparam logic [1:0] CMD_FINISHED = 2'd1;
    localparam logic [1:0] CMD_ALL_OFF  = 2'd2;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    localparam logic [1:0] FULL_COUNT = 2'd3;

    localparam logic [1:0] ACT_CUT     = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_BEND    = 2'd3;

    localparam logic [13:0] BEND_CENTER = 14'd8192;

    localparam int CMP_W = 32;

    typedef enum logic {
        CMP_LT,
        CMP_EQ
    } cmp_op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  voice_index;
        logic [3:0]  out_channel;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [13:0] bend_value;
    } result_t;

    typedef struct packed {
        logic push;
        logic flush;
    } stage_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/poly_voice_allocator_top.sv
// polyphonic voice allocator: voice table, scan sequencer and result channel
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | cmd, status, two data bytes, count, voice
//  m_      | out | m_valid / m_ready  | action, voice, channel, note, velocity,
//          |     |                    | bend, last_of_run
//
// one item at a time; s_ready is high only while the sequencer is idle
// voice finished and ignored items: handled on accept, no scan
// all notes off, bend, note off: a scan over all VOICES, then a flush
// note on: free search, age compare and steal if none free, start, bend, flush
// scans step one voice a cycle unless stalled; release/age use the compare unit
// m_ready low stalls the sequencer only when a result is pushed or flushed
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator_top #(
    parameter int VOICES = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_cmd,
    input  wire  [7:0]  s_status_byte,
    input  wire  [6:0]  s_data_one,
    input  wire  [6:0]  s_data_two,
    input  wire  [1:0]  s_byte_count,
    input  wire  [3:0]  s_finished_voice,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_action,
    output logic [3:0]  m_voice_index,
    output logic [3:0]  m_out_channel,
    output logic [6:0]  m_out_note,
    output logic [6:0]  m_out_velocity,
    output logic [13:0] m_bend_value,
    output logic        m_last_of_run
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);
    localparam logic [VW-1:0] IDX_STEP = VW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CUT   = 4'd1;
    localparam logic [3:0] S_BEND  = 4'd2;
    localparam logic [3:0] S_REL   = 4'd3;
    localparam logic [3:0] S_FREE  = 4'd4;
    localparam logic [3:0] S_OLD   = 4'd5;
    localparam logic [3:0] S_STEAL = 4'd6;
    localparam logic [3:0] S_START = 4'd7;
    localparam logic [3:0] S_SBEND = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [VW-1:0] idx_reg, idx_next;
    logic [VW-1:0] pick_reg, pick_next;
    logic [VW-1:0] best_reg, best_next;
    logic [31:0]   best_age_reg, best_age_next;
    logic [31:0]   age_counter_reg;
    logic [3:0]    chan_reg;
    logic [6:0]    d1_reg;
    logic [6:0]    d2_reg;

    logic          voice_busy_reg [VOICES];
    logic [6:0]    voice_note_reg [VOICES];
    logic [3:0]    voice_chan_reg [VOICES];
    logic [31:0]   voice_age_reg  [VOICES];
    logic [13:0]   channel_bend_reg [16];

    logic          accept;
    logic [3:0]    in_kind;
    logic          in_full;
    logic          fin_ok;

    pva_pkg::cmp_op_t   cmp_op;
    logic [31:0]        cmp_a;
    logic [31:0]        cmp_b;
    logic               cmp_hit;

    pva_pkg::stage_ctl_t stage_ctl;
    pva_pkg::result_t    push_data;
    pva_pkg::result_t    out_data;
    logic                stage_ready;
    logic                out_last;
    logic                take_old;
    logic                start_commit;
    logic                cut_commit;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_kind = s_status_byte[7:4];
    assign in_full = (s_byte_count == pva_pkg::FULL_COUNT);
    assign fin_ok  = ({1'b0, s_finished_voice} < 5'(VOICES));

    // compare operand selection
    always_comb begin
        cmp_op = pva_pkg::CMP_EQ;
        cmp_a  = '0;
        cmp_b  = '0;
        if (state_reg == S_OLD) begin
            cmp_op = pva_pkg::CMP_LT;
            cmp_a  = voice_age_reg[idx_reg];
            cmp_b  = best_age_reg;
        end else begin
            cmp_a = {20'd0, voice_busy_reg[idx_reg], voice_chan_reg[idx_reg],
                     voice_note_reg[idx_reg]};
            cmp_b = {20'd0, 1'b1, chan_reg, d1_reg};
        end
    end

    pva_cmp_unit u_cmp (
        .op  (cmp_op),
        .a   (cmp_a),
        .b   (cmp_b),
        .hit (cmp_hit)
    );

    assign take_old = (idx_reg == '0) || cmp_hit;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        best_age_next = best_age_reg;
        stage_ctl     = '0;
        push_data     = '0;
        start_commit  = 1'b0;
        cut_commit    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    case (s_cmd)
                        pva_pkg::CMD_ALL_OFF: state_next = S_CUT;
                        pva_pkg::CMD_MIDI: begin
                            if (in_full) begin
                                case (in_kind)
                                    pva_pkg::KIND_NOTE_ON:  state_next = S_FREE;
                                    pva_pkg::KIND_NOTE_OFF: state_next = S_REL;
                                    pva_pkg::KIND_BEND:     state_next = S_BEND;
                                    default:                state_next = S_IDLE;
                                endcase
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CUT: begin
                stage_ctl.push        = 1'b1;
                push_data.action      = pva_pkg::ACT_CUT;
                push_data.voice_index = 4'(idx_reg);
                if (stage_ready) begin
                    cut_commit = 1'b1;
                    idx_next   = idx_reg + IDX_STEP;
                    if (idx_reg == LAST_VOICE) state_next = S_FLUSH;
                end
            end
            S_BEND: begin
                stage_ctl.push        = 1'b1;
                push_data.action      = pva_pkg::ACT_BEND;
                push_data.voice_index = 4'(idx_reg);
                push_data.bend_value  = {d2_reg, d1_reg};
                if (stage_ready) begin
                    idx_next = idx_reg + IDX_STEP;
                    if (idx_reg == LAST_VOICE) state_next = S_FLUSH;
                end
            end
            S_REL: begin
                stage_ctl.push        = cmp_hit;
                push_data.action      = pva_pkg::ACT_RELEASE;
                push_data.voice_index = 4'(idx_reg);
                if (stage_ready || !cmp_hit) begin
                    idx_next = idx_reg + IDX_STEP;
                    if (idx_reg == LAST_VOICE) state_next = S_FLUSH;
                end
            end
            S_FREE: begin
                if (!voice_busy_reg[idx_reg]) begin
                    pick_next  = idx_reg;
                    state_next = S_START;
                end else if (idx_reg == LAST_VOICE) begin
                    idx_next   = '0;
                    state_next = S_OLD;
                end else begin
                    idx_next = idx_reg + IDX_STEP;
                end
            end
            S_OLD: begin
                if (take_old) begin
                    best_next     = idx_reg;
                    best_age_next = voice_age_reg[idx_reg];
                end
                if (idx_reg == LAST_VOICE) begin
                    pick_next  = take_old ? idx_reg : best_reg;
                    state_next = S_STEAL;
                end else begin
                    idx_next = idx_reg + IDX_STEP;
                end
            end
            S_STEAL: begin
                stage_ctl.push        = 1'b1;
                push_data.action      = pva_pkg::ACT_CUT;
                push_data.voice_index = 4'(pick_reg);
                if (stage_ready) state_next = S_START;
            end
            S_START: begin
                stage_ctl.push         = 1'b1;
                push_data.action       = pva_pkg::ACT_START;
                push_data.voice_index  = 4'(pick_reg);
                push_data.out_channel  = chan_reg;
                push_data.out_note     = d1_reg;
                push_data.out_velocity = d2_reg;
                if (stage_ready) begin
                    start_commit = 1'b1;
                    state_next   = S_SBEND;
                end
            end
            S_SBEND: begin
                stage_ctl.push        = 1'b1;
                push_data.action      = pva_pkg::ACT_BEND;
                push_data.voice_index = 4'(pick_reg);
                push_data.bend_value  = channel_bend_reg[chan_reg];
                if (stage_ready) state_next = S_FLUSH;
            end
            S_FLUSH: begin
                stage_ctl.flush = 1'b1;
                if (stage_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            age_counter_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (start_commit) age_counter_reg <= age_counter_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        if (accept) begin
            chan_reg <= s_status_byte[3:0];
            d1_reg   <= s_data_one;
            d2_reg   <= s_data_two;
        end
    end

    // voice table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) voice_busy_reg[i] <= 1'b0;
        end else begin
            if (accept && (s_cmd == pva_pkg::CMD_FINISHED) && fin_ok) begin
                voice_busy_reg[s_finished_voice[VW-1:0]] <= 1'b0;
            end
            if (cut_commit) voice_busy_reg[idx_reg] <= 1'b0;
            if (start_commit) voice_busy_reg[pick_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_commit) begin
            voice_note_reg[pick_reg] <= d1_reg;
            voice_chan_reg[pick_reg] <= chan_reg;
            voice_age_reg[pick_reg]  <= age_counter_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) channel_bend_reg[i] <= pva_pkg::BEND_CENTER;
        end else if (accept && (s_cmd == pva_pkg::CMD_MIDI) && in_full
                     && (in_kind == pva_pkg::KIND_BEND)) begin
            channel_bend_reg[s_status_byte[3:0]] <= {s_data_two, s_data_one};
        end
    end

    pva_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (stage_ctl),
        .push_data   (push_data),
        .stage_ready (stage_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .out_data    (out_data),
        .out_last    (out_last)
    );

    assign m_action       = out_data.action;
    assign m_voice_index  = out_data.voice_index;
    assign m_out_channel  = out_data.out_channel;
    assign m_out_note     = out_data.out_note;
    assign m_out_velocity = out_data.out_velocity;
    assign m_bend_value   = out_data.bend_value;
    assign m_last_of_run  = out_last;

endmodule

`default_nettype wire

### hw/rtl/pva_cmp_unit.sv
// shared compare unit: unsigned less-than or equality on one word pair
`timescale 1ns / 1ps
`default_nettype none

module pva_cmp_unit (
    input  var pva_pkg::cmp_op_t           op,
    input  wire  [pva_pkg::CMP_W-1:0]      a,
    input  wire  [pva_pkg::CMP_W-1:0]      b,
    output logic                           hit
);

    always_comb begin
        case (op)
            pva_pkg::CMP_LT: hit = (a < b);
            pva_pkg::CMP_EQ: hit = (a == b);
            default:         hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pva_out_stage.sv
// result staging: one pending result plus the output register
`timescale 1ns / 1ps
`default_nettype none

module pva_out_stage (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  var pva_pkg::stage_ctl_t  ctl,
    input  var pva_pkg::result_t     push_data,
    output logic                     stage_ready,
    output logic                     m_valid,
    input  wire                      m_ready,
    output pva_pkg::result_t         out_data,
    output logic                     out_last
);

    logic              pend_valid_reg, pend_valid_next;
    pva_pkg::result_t  pend_data_reg, pend_data_next;
    logic              out_valid_reg, out_valid_next;
    pva_pkg::result_t  out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_free;
    logic              move;

    assign out_free    = !out_valid_reg || m_ready;
    assign stage_ready = !pend_valid_reg || out_free;
    assign move        = pend_valid_reg && out_free && (ctl.push || ctl.flush);

    always_comb begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_data_next  = pend_data_reg;
            out_last_next  = ctl.flush;
        end
        if (ctl.push && stage_ready) begin
            pend_valid_next = 1'b1;
            pend_data_next  = push_data;
        end else if (ctl.flush && stage_ready) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid  = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire
